@@ rtl/core/jsu_pkg.sv @@
// shared types, codes and helper functions for the json string unescape block
`default_nettype none
package jsu_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 16;
  localparam int REPORT_WIDTH = 16;

  // decoder phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_HEX4 = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_CLOSED  = 2'd1;
  localparam logic [1:0] KIND_NO_OPEN = 2'd2;
  localparam logic [1:0] KIND_UNTERM  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [15:0] ASCII_MAX = 16'd127;

  typedef struct packed {
    logic                    valid;
    logic [1:0]              kind;
    logic [7:0]              decoded_byte;
    logic [REPORT_WIDTH-1:0] decoded_length;
  } result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    case (b)
      8'h62:   v = 8'd8;   // b
      8'h66:   v = 8'd12;  // f
      8'h6E:   v = 8'd10;  // n
      8'h72:   v = 8'd13;  // r
      8'h74:   v = 8'd9;   // t
      default: v = b;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/jsu_step.sv @@
// per-byte decode logic: next phase, accumulator, length and result
`default_nettype none
module jsu_step #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  wire logic [2:0]              phase,
  input  wire logic [15:0]             code_acc,
  input  wire logic [LENGTH_WIDTH-1:0] length_count,
  input  wire logic [7:0]              text_byte,
  output logic [2:0]                   phase_next,
  output logic [15:0]                  code_acc_next,
  output logic [LENGTH_WIDTH-1:0]      length_next,
  output jsu_pkg::result_t             result
);

  logic [31:0] len_ext;
  logic [15:0] len_report;
  logic [15:0] acc_shift;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        count_full;

  assign len_ext = 32'(length_count);
  // reported length saturates at 16 bits
  assign len_report = (|len_ext[31:16]) ? 16'hFFFF : len_ext[15:0];
  assign acc_shift = {code_acc[11:0], jsu_pkg::hex_value(text_byte)};
  assign count_full = &length_count;

  always_comb begin
    phase_next = phase;
    code_acc_next = code_acc;
    length_next = length_count;
    result = '0;
    emit = 1'b0;
    emit_byte = 8'd0;
    if (phase == jsu_pkg::PH_IDLE) begin
      if (text_byte == jsu_pkg::CH_QUOTE) begin
        phase_next = jsu_pkg::PH_BODY;
        length_next = '0;
      end else begin
        result.valid = 1'b1;
        result.kind = jsu_pkg::KIND_NO_OPEN;
      end
    end else if (text_byte == jsu_pkg::CH_NUL) begin
      phase_next = jsu_pkg::PH_IDLE;
      result.valid = 1'b1;
      result.kind = jsu_pkg::KIND_UNTERM;
    end else if (phase == jsu_pkg::PH_BODY) begin
      if (text_byte == jsu_pkg::CH_QUOTE) begin
        phase_next = jsu_pkg::PH_IDLE;
        result.valid = 1'b1;
        result.kind = jsu_pkg::KIND_CLOSED;
        result.decoded_length = len_report;
      end else if (text_byte == jsu_pkg::CH_BSLASH) begin
        phase_next = jsu_pkg::PH_ESC;
      end else begin
        emit = 1'b1;
        emit_byte = text_byte;
      end
    end else if (phase == jsu_pkg::PH_ESC) begin
      if (text_byte == jsu_pkg::CH_U) begin
        code_acc_next = 16'd0;
        phase_next = jsu_pkg::PH_HEX1;
      end else begin
        emit = 1'b1;
        emit_byte = jsu_pkg::escape_map(text_byte);
      end
    end else if (phase >= jsu_pkg::PH_HEX1 && phase <= jsu_pkg::PH_HEX4) begin
      code_acc_next = acc_shift;
      if (phase < jsu_pkg::PH_HEX4) begin
        phase_next = phase + 3'd1;
      end else begin
        emit = 1'b1;
        emit_byte = (acc_shift <= jsu_pkg::ASCII_MAX) ? acc_shift[7:0] : jsu_pkg::CH_QMARK;
      end
    end else begin
      // unused phase code recovers to idle
      phase_next = jsu_pkg::PH_IDLE;
    end

    if (emit) begin
      phase_next = jsu_pkg::PH_BODY;
      if (!count_full) length_next = length_count + 1'b1;
      result.valid = 1'b1;
      result.kind = jsu_pkg::KIND_BYTE;
      result.decoded_byte = emit_byte;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/json_string_unescape_top.sv @@
// top level of the json string unescape block: input register, decode, result register
// path: a request is held in the input register, decoded combinationally and written to
//   the result register once that register is free, so out_stall can hold it in between
// throughput: one byte per cycle unless out_stall holds a full result register
// reset: synchronous active-high rst clears both valid flags, the phase (idle, awaiting
//   opening quote), the code accumulator and the length count
`default_nettype none
module json_string_unescape_top #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       decoded_byte,
  output logic [15:0]      decoded_length
);

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;

  // decoder state
  logic [2:0]              phase;
  logic [15:0]             code_acc;
  logic [LENGTH_WIDTH-1:0] length_count;

  logic [2:0]              phase_next;
  logic [15:0]             code_acc_next;
  logic [LENGTH_WIDTH-1:0] length_next;
  jsu_pkg::result_t        result;

  logic out_free;   // result register can take a new value this edge
  logic consume;    // the held byte is decoded this edge
  logic accept;     // a new request enters the input register

  assign out_free = !out_valid || !out_stall;
  assign consume  = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  jsu_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .phase        (phase),
    .code_acc     (code_acc),
    .length_count (length_count),
    .text_byte    (stage_byte),
    .phase_next   (phase_next),
    .code_acc_next(code_acc_next),
    .length_next  (length_next),
    .result       (result)
  );

  // input register: refills while the held byte drains
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (consume) begin
      stage_valid <= 1'b0;
    end
    if (accept) stage_byte <= text_byte;
  end

  // decoder state advances only when a byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= jsu_pkg::PH_IDLE;
      code_acc     <= 16'd0;
      length_count <= '0;
    end else if (consume) begin
      phase        <= phase_next;
      code_acc     <= code_acc_next;
      length_count <= length_next;
    end
  end

  // result register: bytes that produce no result leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= consume && result.valid;
    end
    if (out_free && consume && result.valid) begin
      kind           <= result.kind;
      decoded_byte   <= result.decoded_byte;
      decoded_length <= result.decoded_length;
    end
  end

endmodule
`default_nettype wire
